### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the sorter checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define MSIC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MSIC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/msic_pkg.sv
// ----------------------------------------------------------------------------
// msic_pkg
// shared constants and types of the merge sort inversion count unit
// ----------------------------------------------------------------------------
`default_nettype none

package msic_pkg;

  // default store depth
  localparam int unsigned MAX_ITEMS_DEF = 64;
  // value width
  localparam int unsigned DATA_W        = 32;
  // inversion counter width and its saturation value
  localparam int unsigned INV_W         = 11;
  localparam logic [INV_W-1:0] INV_SAT  = '1;
  // output word width, value and count padded to whole bytes
  localparam int unsigned OUT_TDATA_W   = 48;

  // merge sequencer status toward the top level
  typedef struct packed {
    logic             done;
    logic             result_sel;
    logic [INV_W-1:0] inversions;
  } merge_status_t;

endpackage

`default_nettype wire

### hw/rtl/msic_mem.sv
// ----------------------------------------------------------------------------
// msic_mem
// value store, one write port and two read ports with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module msic_mem #(
  parameter int unsigned DEPTH = msic_pkg::MAX_ITEMS_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [AW-1:0]               waddr_i,
  input  wire logic [msic_pkg::DATA_W-1:0] wdata_i,
  input  wire logic [AW-1:0]               raddr_a_i,
  input  wire logic [AW-1:0]               raddr_b_i,
  output logic      [msic_pkg::DATA_W-1:0] rdata_a_o,
  output logic      [msic_pkg::DATA_W-1:0] rdata_b_o
);

  logic [msic_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic [msic_pkg::DATA_W-1:0] rdata_a_q;
  logic [msic_pkg::DATA_W-1:0] rdata_b_q;

  // write and registered reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

### hw/rtl/msic_merge.sv
// ----------------------------------------------------------------------------
// msic_merge
// bottom-up merge pass sequencer, ping-pongs between the two stores and
// counts inversions while merging
// ----------------------------------------------------------------------------
`default_nettype none

module msic_merge #(
  parameter int unsigned MAX_ITEMS = msic_pkg::MAX_ITEMS_DEF,
  localparam int unsigned AW       = $clog2(MAX_ITEMS),
  localparam int unsigned CW       = $clog2(MAX_ITEMS + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [CW-1:0]               count_i,
  input  wire logic [msic_pkg::DATA_W-1:0] rd0_a_i,
  input  wire logic [msic_pkg::DATA_W-1:0] rd0_b_i,
  input  wire logic [msic_pkg::DATA_W-1:0] rd1_a_i,
  input  wire logic [msic_pkg::DATA_W-1:0] rd1_b_i,
  output logic      [AW-1:0]               raddr_a_o,
  output logic      [AW-1:0]               raddr_b_o,
  output logic                             we0_o,
  output logic                             we1_o,
  output logic      [AW-1:0]               waddr_o,
  output logic      [msic_pkg::DATA_W-1:0] wdata_o,
  output msic_pkg::merge_status_t          status_o
);

  // room for lo + 2 * width without wrap
  localparam int unsigned IW = CW + 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MERGE
  } state_e;

  state_e                       state_q;
  logic [IW-1:0]                n_q, w_q, lo_q, mid_q, hi_q, i_q, j_q, k_q;
  logic                         src_q;
  logic                         done_q;
  logic [msic_pkg::INV_W-1:0]   inv_q;

  logic [IW-1:0]                lo_w, lo_2w, mid_c, hi_c, w2;
  logic [IW-1:0]                i_nx, j_nx;
  logic [msic_pkg::DATA_W-1:0]  head_a, head_b;
  logic                         left_ok, right_ok, take_a;
  logic                         run_end, pass_end;
  logic [msic_pkg::INV_W:0]     inv_sum;
  logic [msic_pkg::INV_W-1:0]   inv_nx;
  logic                         done_set;

  // run bounds clipped to the set size
  assign lo_w  = lo_q + w_q;
  assign lo_2w = lo_q + (w_q << 1);
  assign w2    = w_q << 1;
  assign mid_c = (lo_w > n_q) ? n_q : lo_w;
  assign hi_c  = (lo_2w > n_q) ? n_q : lo_2w;

  // heads of both halves come from the current source store
  assign head_a = src_q ? rd1_a_i : rd0_a_i;
  assign head_b = src_q ? rd1_b_i : rd0_b_i;

  // pick the next word, left wins ties to keep the sort stable
  assign left_ok  = i_q < mid_q;
  assign right_ok = j_q < hi_q;
  assign take_a   = left_ok && (!right_ok || ($signed(head_a) <= $signed(head_b)));
  assign i_nx     = take_a ? i_q + IW'(1) : i_q;
  assign j_nx     = take_a ? j_q : j_q + IW'(1);

  // every word still waiting on the left forms an inversion, saturating
  assign inv_sum = {1'b0, inv_q} + (msic_pkg::INV_W + 1)'(mid_q - i_q);
  assign inv_nx  = (left_ok && !take_a)
                 ? (inv_sum[msic_pkg::INV_W] ? msic_pkg::INV_SAT
                                             : inv_sum[msic_pkg::INV_W-1:0])
                 : inv_q;

  assign run_end  = (k_q + IW'(1)) == hi_q;
  assign pass_end = lo_2w >= n_q;

  // done after a trivial set or after the last pass
  assign done_set = ((state_q == ST_IDLE) && start_i && (count_i <= CW'(1)))
                 || ((state_q == ST_MERGE) && run_end && pass_end && (w2 >= n_q));

  // read the next heads so they are ready in the next cycle
  assign raddr_a_o = (state_q == ST_MERGE) ? i_nx[AW-1:0] : lo_q[AW-1:0];
  assign raddr_b_o = (state_q == ST_MERGE) ? j_nx[AW-1:0] : mid_c[AW-1:0];

  // destination is the store that is not the source
  assign we0_o   = (state_q == ST_MERGE) && src_q;
  assign we1_o   = (state_q == ST_MERGE) && !src_q;
  assign waddr_o = k_q[AW-1:0];
  assign wdata_o = take_a ? head_a : head_b;

  assign status_o.done       = done_q;
  assign status_o.result_sel = src_q;
  assign status_o.inversions = inv_q;

  // pass and run sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
      w_q     <= '0;
      lo_q    <= '0;
      mid_q   <= '0;
      hi_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      src_q   <= 1'b0;
      done_q  <= 1'b0;
      inv_q   <= '0;
    end else begin
      done_q <= done_set;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            n_q   <= IW'(count_i);
            w_q   <= IW'(1);
            lo_q  <= '0;
            src_q <= 1'b0;
            inv_q <= '0;
            if (count_i > CW'(1)) begin
              state_q <= ST_SETUP;
            end
          end
        end
        ST_SETUP: begin
          mid_q   <= mid_c;
          hi_q    <= hi_c;
          i_q     <= lo_q;
          j_q     <= mid_c;
          k_q     <= lo_q;
          state_q <= ST_MERGE;
        end
        ST_MERGE: begin
          i_q   <= i_nx;
          j_q   <= j_nx;
          k_q   <= k_q + IW'(1);
          inv_q <= inv_nx;
          if (run_end) begin
            if (pass_end) begin
              src_q <= ~src_q;
              w_q   <= w2;
              lo_q  <= '0;
              if (w2 >= n_q) begin
                state_q <= ST_IDLE;
              end else begin
                state_q <= ST_SETUP;
              end
            end else begin
              lo_q    <= lo_2w;
              state_q <= ST_SETUP;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/merge_sort_inversion_count_unit.sv
// ----------------------------------------------------------------------------
// merge_sort_inversion_count_unit
// collects a set of signed values, sorts it stably by bottom-up merge sort,
// counts inversions and streams the sorted set out
// ----------------------------------------------------------------------------
//  channel   dir  tdata                            tlast        tuser
//  s_axis    in   [31:0] sample_value              final_item   -
//  m_axis    out  [31:0] sorted_value,             run_end      overflow_seen
//                 [42:32] inversion_total, zero pad
//
//  load accepts a word whenever the source offers one; input is taken only while loading
//  sorting takes ceil(log2 n) passes, each run a setup step then a merge
//  step per word, bound by the single write port of the destination store
//  output reads each word from the store, then loads the output register,
//  waiting while the sink stalls; the next set loads as the last word waits
//  no clearing pass after reset; stores are written before they are read
// ----------------------------------------------------------------------------
`default_nettype none

module merge_sort_inversion_count_unit #(
  parameter int unsigned MAX_ITEMS = msic_pkg::MAX_ITEMS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  wire logic [msic_pkg::DATA_W-1:0]      s_axis_tdata_i,  // sample_value
  input  wire logic                             s_axis_tlast_i,  // final_item
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // sorted_value, inversion_total, zero pad
  output logic      [msic_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                                  m_axis_tlast_o,  // run_end
  output logic                                  m_axis_tuser_o   // overflow_seen
);

  localparam int unsigned AW    = $clog2(MAX_ITEMS);
  localparam int unsigned CW    = $clog2(MAX_ITEMS + 1);
  localparam int unsigned PAD_W = msic_pkg::OUT_TDATA_W - msic_pkg::DATA_W
                                  - msic_pkg::INV_W;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT_RD,
    ST_EMIT_WAIT
  } state_e;

  state_e                        state_q;
  logic [CW-1:0]                 cnt_q;
  logic [CW-1:0]                 k_q;
  logic                          drop_q;
  logic                          res_sel_q;
  logic [msic_pkg::INV_W-1:0]    inv_q;
  logic                          m_valid_q;
  logic                          m_last_q;
  logic                          m_drop_q;
  logic [msic_pkg::DATA_W-1:0]   m_data_q;
  logic [msic_pkg::INV_W-1:0]    m_inv_q;

  logic                          in_acc, has_room, start, out_free, last_k;
  logic [CW-1:0]                 count_new;
  logic                          emitting;
  logic                          emit_fire;

  logic [AW-1:0]                 mg_raddr_a, mg_raddr_b, mg_waddr;
  logic                          mg_we0, mg_we1;
  logic [msic_pkg::DATA_W-1:0]   mg_wdata;
  msic_pkg::merge_status_t       mg_status;

  logic                          m0_we;
  logic [AW-1:0]                 m0_waddr, rd_addr_a;
  logic [msic_pkg::DATA_W-1:0]   m0_wdata;
  logic [msic_pkg::DATA_W-1:0]   rd0_a, rd0_b, rd1_a, rd1_b, rd_emit;

  // input side
  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign in_acc          = s_axis_tvalid_i && (state_q == ST_LOAD);
  assign has_room        = cnt_q < CW'(MAX_ITEMS);
  assign count_new       = has_room ? cnt_q + CW'(1) : cnt_q;
  assign start           = in_acc && s_axis_tlast_i;

  // primary store is written by the loader and by even merge passes
  assign m0_we    = (in_acc && has_room) || mg_we0;
  assign m0_waddr = in_acc ? cnt_q[AW-1:0] : mg_waddr;
  assign m0_wdata = in_acc ? s_axis_tdata_i : mg_wdata;

  // output reads share port a of both stores
  assign emitting  = (state_q == ST_EMIT_RD) || (state_q == ST_EMIT_WAIT);
  assign rd_addr_a = emitting ? k_q[AW-1:0] : mg_raddr_a;
  assign rd_emit   = res_sel_q ? rd1_a : rd0_a;
  assign out_free  = !m_valid_q || m_axis_tready_i;
  assign last_k    = (k_q + CW'(1)) == cnt_q;
  assign emit_fire = (state_q == ST_EMIT_WAIT) && out_free;

  msic_mem #(
    .DEPTH (MAX_ITEMS)
  ) u_mem_primary (
    .clk_i     (clk_i),
    .we_i      (m0_we),
    .waddr_i   (m0_waddr),
    .wdata_i   (m0_wdata),
    .raddr_a_i (rd_addr_a),
    .raddr_b_i (mg_raddr_b),
    .rdata_a_o (rd0_a),
    .rdata_b_o (rd0_b)
  );

  msic_mem #(
    .DEPTH (MAX_ITEMS)
  ) u_mem_merge (
    .clk_i     (clk_i),
    .we_i      (mg_we1),
    .waddr_i   (mg_waddr),
    .wdata_i   (mg_wdata),
    .raddr_a_i (rd_addr_a),
    .raddr_b_i (mg_raddr_b),
    .rdata_a_o (rd1_a),
    .rdata_b_o (rd1_b)
  );

  msic_merge #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .count_i   (count_new),
    .rd0_a_i   (rd0_a),
    .rd0_b_i   (rd0_b),
    .rd1_a_i   (rd1_a),
    .rd1_b_i   (rd1_b),
    .raddr_a_o (mg_raddr_a),
    .raddr_b_o (mg_raddr_b),
    .we0_o     (mg_we0),
    .we1_o     (mg_we1),
    .waddr_o   (mg_waddr),
    .wdata_o   (mg_wdata),
    .status_o  (mg_status)
  );

  // control state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      cnt_q     <= '0;
      k_q       <= '0;
      drop_q    <= 1'b0;
      res_sel_q <= 1'b0;
      inv_q     <= '0;
      m_valid_q <= 1'b0;
      m_last_q  <= 1'b0;
      m_drop_q  <= 1'b0;
      m_data_q  <= '0;
      m_inv_q   <= '0;
    end else begin
      if (m_valid_q && m_axis_tready_i && !emit_fire) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            cnt_q <= count_new;
            if (!has_room) begin
              drop_q <= 1'b1;
            end
            if (s_axis_tlast_i) begin
              state_q <= ST_SORT;
            end
          end
        end
        ST_SORT: begin
          if (mg_status.done) begin
            res_sel_q <= mg_status.result_sel;
            inv_q     <= mg_status.inversions;
            k_q       <= '0;
            state_q   <= ST_EMIT_RD;
          end
        end
        ST_EMIT_RD: begin
          state_q <= ST_EMIT_WAIT;
        end
        ST_EMIT_WAIT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= rd_emit;
            m_last_q  <= last_k;
            m_inv_q   <= inv_q;
            m_drop_q  <= drop_q;
            if (last_k) begin
              cnt_q   <= '0;
              drop_q  <= 1'b0;
              state_q <= ST_LOAD;
            end else begin
              k_q     <= k_q + CW'(1);
              state_q <= ST_EMIT_RD;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{PAD_W{1'b0}}, m_inv_q, m_data_q};
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tuser_o  = m_drop_q;

endmodule

`default_nettype wire

### hw/rtl/msic_checker.sv
// ----------------------------------------------------------------------------
// msic_checker
// port level checks of the merge sort inversion count unit
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module msic_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             s_axis_tvalid_i,
  input wire logic                             s_axis_tready_i,
  input wire logic                             s_axis_tlast_i,
  input wire logic                             m_axis_tvalid_i,
  input wire logic                             m_axis_tready_i,
  input wire logic [msic_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i
);

  logic out_stall;
  logic last_in;

  // stalled output word and final input word
  assign out_stall = m_axis_tvalid_i && !m_axis_tready_i;
  assign last_in   = s_axis_tvalid_i && s_axis_tready_i && s_axis_tlast_i;

  // a stalled output word holds its data
  `MSIC_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> $stable(m_axis_tdata_i), "stalled word moved")

  // the last input word of a set stops intake while the set is sorted
  `MSIC_ASSERT(a_busy_after_last, clk_i, rst_ni, last_in |=> !s_axis_tready_i, "input after set end")

  // no output word during reset
  `MSIC_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !m_axis_tvalid_i, "output valid in reset")

endmodule

bind merge_sort_inversion_count_unit msic_checker u_msic_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);

`default_nettype wire

### verif/msic_sort_checker.sv
// ----------------------------------------------------------------------------
// msic_sort_checker
// watches both streams of the merge sort inversion count unit, rebuilds each
// set from the input words, predicts the sorted run with its inversion total
// and drop flag, and compares every output word against the oldest prediction
// ----------------------------------------------------------------------------

module msic_sort_checker #(
  parameter int unsigned MAX_ITEMS = msic_pkg::MAX_ITEMS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  input  logic                             s_axis_tready_i,
  input  logic [msic_pkg::DATA_W-1:0]      s_axis_tdata_i,  // sample_value
  input  logic                             s_axis_tlast_i,  // final_item
  input  logic                             m_axis_tvalid_i,
  input  logic                             m_axis_tready_i,
  // sorted_value, inversion_total, zero pad
  input  logic [msic_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i,
  input  logic                             m_axis_tlast_i,  // run_end
  input  logic                             m_axis_tuser_i,  // overflow_seen
  output int                               fail_count_o,
  output int                               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned      DATA_W  = msic_pkg::DATA_W;
  localparam int unsigned      INV_W   = msic_pkg::INV_W;
  localparam logic [INV_W-1:0] INV_SAT = msic_pkg::INV_SAT;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              run_end;
    logic [INV_W-1:0]  inversions;
    logic              overflow;
  } sorted_word_t;

  // values of the set being loaded, and the drop flag of that set
  logic [DATA_W-1:0] set_values[$];
  logic              set_dropped;
  // sorted words still to come out of the block
  sorted_word_t      sorted_words[$];

  initial begin
    set_dropped = 1'b0;
  end

  // store one input word; on the final word sort the set and queue the run
  task automatic load_word(input logic [DATA_W-1:0] val, input logic fin);
    logic [DATA_W-1:0] order[$];
    logic [DATA_W-1:0] key;
    int unsigned       inv;
    int                j;
    sorted_word_t      w;
    if (set_values.size() < MAX_ITEMS) begin
      set_values = {set_values, val};
    end else begin
      set_dropped = 1'b1;
    end
    if (fin) begin
      order = set_values;
      inv = 0;
      // stable insertion sort: every shift past a strictly greater value
      // undoes exactly one inversion
      for (int i = 1; i < order.size(); i++) begin
        key = order[i];
        j = i - 1;
        while (j >= 0 && $signed(order[j]) > $signed(key)) begin
          order[j+1] = order[j];
          j--;
          inv++;
        end
        order[j+1] = key;
      end
      if (inv > INV_SAT) begin
        inv = INV_SAT;
      end
      foreach (order[k]) begin
        w.value      = order[k];
        w.run_end    = (k == order.size() - 1);
        w.inversions = inv[INV_W-1:0];
        w.overflow   = set_dropped;
        sorted_words = {sorted_words, w};
      end
      set_values.delete();
      set_dropped = 1'b0;
    end
  endtask

  // compare one output word with the oldest queued prediction
  task automatic check_word(input logic [DATA_W-1:0] val, input logic [INV_W-1:0] inv,
                            input logic fin, input logic ovf);
    sorted_word_t want;
    if (sorted_words.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10) begin
        $display("%0t: unexpected word: value %0d count %0d last %b drop %b",
                 $time, $signed(val), inv, fin, ovf);
      end
    end else begin
      want = sorted_words.pop_front();
      if (want.value !== val || want.inversions !== inv ||
          want.run_end !== fin || want.overflow !== ovf) begin
        fail_count_o++;
        if (fail_count_o <= 10) begin
          $display("%0t: mismatch: exp value %0d count %0d last %b drop %b", $time,
                   $signed(want.value), want.inversions, want.run_end, want.overflow);
          $display("%0t:           got value %0d count %0d last %b drop %b", $time,
                   $signed(val), inv, fin, ovf);
        end
      end
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        load_word(s_axis_tdata_i, s_axis_tlast_i);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        check_word(m_axis_tdata_i[DATA_W-1:0], m_axis_tdata_i[DATA_W+INV_W-1:DATA_W],
                   m_axis_tlast_i, m_axis_tuser_i);
      end
    end
    pending_o = sorted_words.size();
  end

endmodule

### verif/tb_merge_sort_inversion_count_unit.sv
// ----------------------------------------------------------------------------
// tb_merge_sort_inversion_count_unit
// drives sets of signed values into the sorter: a directed part with extreme
// values, equal values and a reversed set, then random sets including one that
// overflows the store; both sides idle in random bursts and the sink holds
// off once for a long stretch; the checker predicts and compares every word
// ----------------------------------------------------------------------------

module tb_merge_sort_inversion_count_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DATA_W      = msic_pkg::DATA_W;
  localparam int unsigned OUT_TDATA_W = msic_pkg::OUT_TDATA_W;
  localparam int unsigned MAX_ITEMS   = msic_pkg::MAX_ITEMS_DEF;
  // a full set sorts in about six passes
  localparam int          STALL_LIMIT = 5000;
  localparam int          LONG_HOLD   = 300;
  localparam int          HOLD_AFTER  = 30;
  localparam int          RAND_ITEMS  = 88;
  localparam int          CALM_ITEMS  = 13;
  localparam int          DRAIN       = 40;
  localparam int          DIR_ITEMS   = 22;

  localparam logic [DATA_W-1:0] MIN_V = 32'h8000_0000;
  localparam logic [DATA_W-1:0] MAX_V = 32'h7fff_ffff;

  typedef enum int {
    VAL_ANY,
    VAL_NEAR_ZERO,
    VAL_EXTREME,
    VAL_SHORT
  } value_kind_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [DATA_W-1:0]      s_axis_tdata_i;   // sample_value
  logic                   s_axis_tlast_i;   // final_item
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;   // sorted_value, inversion_total, zero pad
  logic                   m_axis_tlast_o;   // run_end
  logic                   m_axis_tuser_o;   // overflow_seen

  int fail_count;
  int pending;
  int sorted_out = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;

  // directed sets: single min, single max, max then min, equal values,
  // values around zero, a reversed set and a mix of extremes
  logic [DATA_W-1:0] dir_vals [DIR_ITEMS] = '{
    MIN_V,
    MAX_V,
    MAX_V, MIN_V,
    32'd5, 32'd5, 32'd5,
    32'd0, 32'hffff_ffff, 32'd1, 32'hffff_ffff,
    32'd4, 32'd3, 32'd2, 32'd1, 32'd0,
    MIN_V, MAX_V, 32'd0, 32'hffff_ffff, MAX_V, MIN_V
  };
  bit dir_last [DIR_ITEMS] = '{
    1,
    1,
    0, 1,
    0, 0, 1,
    0, 0, 0, 1,
    0, 0, 0, 0, 1,
    0, 0, 0, 0, 0, 1
  };

  merge_sort_inversion_count_unit #(
    .MAX_ITEMS(MAX_ITEMS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  msic_sort_checker #(
    .MAX_ITEMS(MAX_ITEMS)
  ) i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_i (m_axis_tdata_o),
    .m_axis_tlast_i (m_axis_tlast_o),
    .m_axis_tuser_i (m_axis_tuser_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // count output words for the sink's long hold-off
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sorted_out++;
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // random value of the requested kind
  function automatic logic [DATA_W-1:0] pick_value(input value_kind_e kind);
    logic [DATA_W-1:0] raw;
    raw = $urandom;
    case (kind)
      VAL_ANY: begin
        return raw;
      end
      VAL_NEAR_ZERO: begin
        return DATA_W'($urandom_range(0, 6)) - DATA_W'(3);
      end
      VAL_EXTREME: begin
        case (raw[1:0])
          2'd0: return MIN_V;
          2'd1: return MAX_V;
          2'd2: return '0;
          default: return '1;
        endcase
      end
      default: begin
        return {{17{raw[15]}}, raw[14:0]};
      end
    endcase
  endfunction

  // offer one word, with an occasional idle burst first, and wait for it
  task automatic send_word(input logic [DATA_W-1:0] val, input logic fin);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
    end
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= val;
    s_axis_tlast_i  <= fin;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // sink: random stall bursts, one long hold-off, none in the calm tail
  initial begin
    int  burst;
    bit  held;
    burst = 0;
    held = 1'b0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && sorted_out >= HOLD_AFTER) begin
        held = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end
      if (calm) begin
        m_axis_tready_i <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        m_axis_tready_i <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 4) - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // stimulus and verdict
  initial begin
    int          rand_sent;
    int          set_no;
    int          n;
    value_kind_e kind;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed sets
    for (int i = 0; i < DIR_ITEMS; i++) begin
      send_word(dir_vals[i], dir_last[i]);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    // sender pauses until every directed word is out
    wait (pending == 0);

    // random sets, the third one fills the store and overflows it
    rand_sent = 0;
    set_no = 0;
    while (rand_sent < RAND_ITEMS) begin
      if (rand_sent >= RAND_ITEMS - CALM_ITEMS) begin
        calm = 1'b1;
      end
      if (set_no == 2) begin
        // reversed full set for the largest count, then dropped words
        n = MAX_ITEMS + $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
          send_word((i < MAX_ITEMS) ? MAX_V - DATA_W'(i) * 32'h0100_0000 : pick_value(VAL_ANY),
                    i == n - 1);
        end
      end else begin
        n = $urandom_range(1, 12);
        kind = value_kind_e'($urandom_range(0, 3));
        for (int i = 0; i < n; i++) begin
          send_word(pick_value(kind), i == n - 1);
        end
      end
      rand_sent += n;
      set_no++;
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
